/* rtl/ecd_pkg.sv */
package ecd_pkg;

	localparam logic [7:0] ChBs     = 8'h08;
	localparam logic [7:0] ChHt     = 8'h09;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChVt     = 8'h0B;
	localparam logic [7:0] ChFf     = 8'h0C;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChNul    = 8'h00;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChSeven  = 8'h37;
	localparam logic [7:0] ChLowB   = 8'h62;
	localparam logic [7:0] ChLowC   = 8'h63;
	localparam logic [7:0] ChLowF   = 8'h66;
	localparam logic [7:0] ChLowN   = 8'h6E;
	localparam logic [7:0] ChLowR   = 8'h72;
	localparam logic [7:0] ChLowT   = 8'h74;
	localparam logic [7:0] ChLowV   = 8'h76;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [2:0] ADDR_QUOTE_MODE = 3'd0;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_byte;
		logic       final_arg;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       stopped;
		logic       run_last;
	} res_t;

	// one queue entry: all results of one item
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	typedef struct packed {
		logic   empty;
		logic   full;
		entry_t head;
	} qstat_t;

endpackage

/* rtl/ecd_front.sv */
module ecd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          quote_mode,
	input  logic          accept,
	input  ecd_pkg::req_t req,
	output logic          push,
	output ecd_pkg::entry_t entry
);
	import ecd_pkg::*;

	typedef enum logic [1:0] {
		M_NORMAL,
		M_ESCAPE,
		M_OCTAL
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [8:0] oval_q, oval_d;
	logic [1:0] odig_q, odig_d;
	logic       halted_q, halted_d;

	logic [1:0] cnt;
	res_t       r0, r1;
	logic [8:0] oval_sh;
	logic       is_digit;
	logic [7:0] c;

	assign c        = req.char_byte;
	assign oval_sh  = {oval_q[5:0], c[2:0]};
	assign is_digit = (c >= ChZero) && (c <= ChSeven);

	always_comb begin
		mode_d   = mode_q;
		oval_d   = oval_q;
		odig_d   = odig_q;
		halted_d = halted_q;
		cnt      = 2'd0;
		r0       = '{out_byte: 8'h00, byte_valid: 1'b1, stopped: 1'b0, run_last: 1'b0};
		r1       = r0;
		if (!halted_q) begin
			if (req.req_type == REQ_END) begin
				mode_d = M_NORMAL;
				oval_d = '0;
				odig_d = '0;
				if (mode_q == M_ESCAPE || mode_q == M_OCTAL) begin
					r0.out_byte = (mode_q == M_ESCAPE) ? ChBslash : oval_q[7:0];
					r1.out_byte = req.final_arg ? (quote_mode ? ChNul : ChLf) : ChSpace;
					cnt = 2'd2;
				end else begin
					r0.out_byte = req.final_arg ? (quote_mode ? ChNul : ChLf) : ChSpace;
					cnt = 2'd1;
				end
			end else begin
				unique case (mode_q)
					M_ESCAPE: begin
						mode_d = M_NORMAL;
						cnt = 2'd1;
						case (c)
							ChLowB:   r0.out_byte = ChBs;
							ChLowF:   r0.out_byte = ChFf;
							ChLowN:   r0.out_byte = ChLf;
							ChLowR:   r0.out_byte = ChCr;
							ChLowT:   r0.out_byte = ChHt;
							ChLowV:   r0.out_byte = ChVt;
							ChBslash: r0.out_byte = ChBslash;
							ChLowC: begin
								halted_d      = 1'b1;
								r0.byte_valid = 1'b0;
								r0.stopped    = 1'b1;
							end
							ChZero: begin
								mode_d = M_OCTAL;
								oval_d = '0;
								odig_d = '0;
								cnt    = 2'd0;
							end
							default: begin
								r0.out_byte = ChBslash;
								if (c == ChBslash) begin
									mode_d = M_ESCAPE;
								end else begin
									r1.out_byte = c;
									cnt = 2'd2;
								end
							end
						endcase
					end
					M_OCTAL: begin
						if (is_digit) begin
							oval_d = oval_sh;
							odig_d = odig_q + 2'd1;
							if (odig_q == 2'd2) begin
								r0.out_byte = oval_sh[7:0];
								cnt    = 2'd1;
								mode_d = M_NORMAL;
								oval_d = '0;
								odig_d = '0;
							end
						end else begin
							r0.out_byte = oval_q[7:0];
							oval_d = '0;
							odig_d = '0;
							cnt    = 2'd1;
							if (c == ChBslash) begin
								mode_d = M_ESCAPE;
							end else begin
								mode_d = M_NORMAL;
								r1.out_byte = c;
								cnt = 2'd2;
							end
						end
					end
					default: begin
						if (quote_mode && (c == ChBslash || c == ChSpace)) begin
							r0.out_byte = ChBslash;
							r1.out_byte = c;
							cnt = 2'd2;
						end else if (c == ChBslash) begin
							mode_d = M_ESCAPE;
						end else begin
							r0.out_byte = c;
							cnt = 2'd1;
						end
					end
				endcase
			end
		end
		if (cnt == 2'd2) begin
			r1.run_last = 1'b1;
		end else begin
			r0.run_last = 1'b1;
		end
	end

	assign push  = accept && (cnt != 2'd0);
	assign entry = '{two: (cnt == 2'd2), r0: r0, r1: r1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_NORMAL;
			oval_q   <= '0;
			odig_q   <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			oval_q   <= oval_d;
			odig_q   <= odig_d;
			halted_q <= halted_d;
		end
	end

endmodule

/* rtl/ecd_queue.sv */
module ecd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ecd_pkg::entry_t wdata,
	input  logic            pop,
	output ecd_pkg::qstat_t stat
);
	import ecd_pkg::*;

	entry_t           mem_q [QDepth];
	logic [QAw-1:0]   wptr_q, rptr_q;
	logic [QAw:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QAw+1)'(QDepth));
	assign stat.head  = mem_q[rptr_q];

endmodule

/* rtl/ecd_back.sv */
module ecd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ecd_pkg::qstat_t stat,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output ecd_pkg::res_t   res_data
);
	import ecd_pkg::*;

	logic sel_q;
	logic take;

	assign res_valid = !stat.empty;
	assign res_data  = sel_q ? stat.head.r1 : stat.head.r0;
	assign take      = res_valid && !res_stall;
	assign pop       = take && (sel_q || !stat.head.two);

	// second result of a two-result entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !sel_q && stat.head.two;
		end
	end

endmodule

/* rtl/echo_escape_decoder_unit.sv */
// A result is offered once its item is accepted and prior ones are taken.
// Throughput: one item per cycle while the queue is not full; a 4-entry
// queue absorbs the extra output time of items that yield two results.
// Reset (arst_n low, asynchronous): normal scan mode, octal run cleared,
// stop flag cleared, queue emptied, quote_mode 0.
module echo_escape_decoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ecd_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output ecd_pkg::res_t res_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import ecd_pkg::*;

	logic   quote_mode_q;
	logic   accept, push, pop;
	entry_t entry;
	qstat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_QUOTE_MODE[2]) ? {31'd0, quote_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_QUOTE_MODE[2]) begin
			quote_mode_q <= pwdata[0];
		end
	end

	assign req_stall = stat.full;
	assign accept    = req_valid && !req_stall;

	ecd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.quote_mode (quote_mode_q),
		.accept     (accept),
		.req        (req_data),
		.push       (push),
		.entry      (entry)
	);

	ecd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.stat   (stat)
	);

	ecd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

/* tb/tb_echo_escape_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_echo_escape_decoder_unit;
	import ecd_pkg::*;

	localparam int IdleLimit  = 4000;
	localparam int HoldCycles = 240;
	localparam int PhaseItems = 250;

	typedef enum logic [1:0] {
		SCAN_NORMAL,
		SCAN_ESCAPE,
		SCAN_OCTAL
	} scan_e;

	// expected-output tracker: mirrors the decoder state and queues the bytes it owes
	class escape_scoreboard;
		bit         quote;
		scan_e      scan;
		logic [8:0] oct_val;
		logic [1:0] oct_cnt;
		bit         halted;
		res_t       expected_q[$];
		res_t       fresh[$];
		int         errors;
		int         n_results;
		int         n_stops;

		function new();
			quote     = 1'b0;
			scan      = SCAN_NORMAL;
			oct_val   = '0;
			oct_cnt   = '0;
			halted    = 1'b0;
			errors    = 0;
			n_results = 0;
			n_stops   = 0;
		endfunction

		function void put(logic [7:0] b, logic v, logic s);
			res_t r;
			r.out_byte   = b;
			r.byte_valid = v;
			r.stopped    = s;
			r.run_last   = 1'b0;
			fresh.push_back(r);
		endfunction

		function void pass_plain(logic [7:0] c);
			if (c == ChBslash) begin
				scan = SCAN_ESCAPE;
			end else begin
				scan = SCAN_NORMAL;
				put(c, 1'b1, 1'b0);
			end
		endfunction

		function void decode_escape(logic [7:0] c);
			scan = SCAN_NORMAL;
			case (c)
				ChLowB: put(ChBs, 1'b1, 1'b0);
				ChLowF: put(ChFf, 1'b1, 1'b0);
				ChLowN: put(ChLf, 1'b1, 1'b0);
				ChLowR: put(ChCr, 1'b1, 1'b0);
				ChLowT: put(ChHt, 1'b1, 1'b0);
				ChLowV: put(ChVt, 1'b1, 1'b0);
				ChBslash: put(ChBslash, 1'b1, 1'b0);
				ChLowC: begin
					halted = 1'b1;
					put(ChNul, 1'b0, 1'b1);
				end
				ChZero: begin
					scan    = SCAN_OCTAL;
					oct_val = '0;
					oct_cnt = '0;
				end
				default: begin
					put(ChBslash, 1'b1, 1'b0);
					pass_plain(c);
				end
			endcase
		endfunction

		function void note_item(req_t it);
			res_t       r;
			logic [7:0] c;
			c = it.char_byte;
			fresh.delete();
			if (halted)
				return;
			if (it.req_type == REQ_END) begin
				if (scan == SCAN_ESCAPE)
					put(ChBslash, 1'b1, 1'b0);
				else if (scan == SCAN_OCTAL)
					put(oct_val[7:0], 1'b1, 1'b0);
				scan    = SCAN_NORMAL;
				oct_val = '0;
				oct_cnt = '0;
				put(it.final_arg ? (quote ? ChNul : ChLf) : ChSpace, 1'b1, 1'b0);
			end else if (scan == SCAN_ESCAPE) begin
				decode_escape(c);
			end else if (scan == SCAN_OCTAL) begin
				if (c >= ChZero && c <= ChSeven) begin
					oct_val = {oct_val[5:0], 3'(c - ChZero)};
					oct_cnt = oct_cnt + 2'd1;
					if (oct_cnt == 2'd3) begin
						put(oct_val[7:0], 1'b1, 1'b0);
						scan    = SCAN_NORMAL;
						oct_val = '0;
						oct_cnt = '0;
					end
				end else begin
					put(oct_val[7:0], 1'b1, 1'b0);
					oct_val = '0;
					oct_cnt = '0;
					pass_plain(c);
				end
			end else if (quote && (c == ChBslash || c == ChSpace)) begin
				put(ChBslash, 1'b1, 1'b0);
				put(c, 1'b1, 1'b0);
			end else begin
				pass_plain(c);
			end
			if (fresh.size() > 0) begin
				r = fresh.pop_back();
				r.run_last = 1'b1;
				fresh.push_back(r);
			end
			foreach (fresh[i])
				expected_q.push_back(fresh[i]);
		endfunction

		function void cmp(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			n_results++;
			if (got.stopped === 1'b1)
				n_stops++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			cmp("out_byte", want.out_byte, got.out_byte);
			cmp("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
			cmp("stopped", 8'(want.stopped), 8'(got.stopped));
			cmp("run_last", 8'(want.run_last), 8'(got.run_last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req_data;
	logic        res_valid;
	logic        res_stall;
	res_t        res_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	escape_scoreboard sb;
	escape_scoreboard shadow;
	req_t             plan_q[$];
	int               burst_left;
	int               n_items;
	int               n_directed;
	int               reg_errors;
	int               idle_cycles;
	bit               stop_allowed;
	bit               hold_armed;
	bit               hold_done;
	logic [7:0]       esc_letters [0:6] = '{ChLowB, ChLowF, ChLowN, ChLowR, ChLowT, ChLowV,
		ChBslash};

	echo_escape_decoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// planning runs items through a shadow copy so a stop escape is only placed on purpose
	function automatic void push_req(logic rt, logic [7:0] ch, logic fin);
		req_t it;
		it.req_type  = rt;
		it.char_byte = ch;
		it.final_arg = fin;
		if (!stop_allowed && rt == REQ_BYTE && shadow.scan == SCAN_ESCAPE && ch == ChLowC)
			it.char_byte = ChLowC + 8'd1;
		shadow.note_item(it);
		shadow.expected_q.delete();
		plan_q.push_back(it);
	endfunction

	function automatic void push_byte(logic [7:0] ch);
		push_req(REQ_BYTE, ch, 1'($urandom_range(0, 1)));
	endfunction

	function automatic void push_esc(logic [7:0] ch);
		push_byte(ChBslash);
		push_byte(ch);
	endfunction

	function automatic void gen_arg();
		int         nseg;
		int         ndig;
		logic [7:0] c;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 6))
				push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			return;
		end
		nseg = $urandom_range(0, 6);
		repeat (nseg) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					c = 8'($urandom_range(8'h21, 8'h7E));
					push_byte(c == ChBslash ? ChSpace : c);
				end
				3: push_byte(ChSpace);
				4, 5: push_esc(esc_letters[$urandom_range(0, 6)]);
				6, 7: begin
					push_esc(ChZero);
					ndig = $urandom_range(0, 3);
					repeat (ndig)
						push_byte(ChZero + 8'($urandom_range(0, 7)));
					if (ndig < 3 && $urandom_range(0, 1))
						push_byte(8'($urandom_range(8'h20, 8'h7E)));
				end
				8: push_esc(8'($urandom_range(1, 255)));
				default: push_byte(ChBslash);
			endcase
		end
		push_req(REQ_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 5) == 0));
	endfunction

	task automatic drive_plan();
		req_t it;
		int   gap;
		while (plan_q.size() > 0) begin
			it = plan_q.pop_front();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			req_data  <= it;
			req_valid <= 1'b1;
			@(posedge clk);
			while (req_stall) @(posedge clk);
			sb.note_item(it);
			n_items++;
		end
		req_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_quote(logic v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_QUOTE_MODE;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.quote     = v;
		shadow.quote = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== 32'(v)) begin
			reg_errors++;
			$display("%0t: quote_mode readback, expected %h, actual %h", $time, 32'(v), prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(logic q);
		write_quote(q);
		while (plan_q.size() < PhaseItems)
			gen_arg();
		drive_plan();
		wait_drain();
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_data);
	end

	// receiver: changing stall patterns, plus one long hold-off once armed
	initial begin
		int mode;
		int left;
		left = 0;
		mode = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 3) == 0);
				2: res_stall <= ($urandom_range(0, 3) != 0);
				default: res_stall <= ~res_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no progress for %0d cycles", $time, IdleLimit);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic q_plan [0:5];
		q_plan       = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		sb           = new();
		shadow       = new();
		n_items      = 0;
		reg_errors   = 0;
		idle_cycles  = 0;
		burst_left   = 0;
		stop_allowed = 1'b0;
		hold_armed   = 1'b0;
		hold_done    = 1'b0;
		arst_n       = 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: escapes, octal wrap, short octal run into a new escape, cut-offs
		write_quote(1'b0);
		push_req(REQ_BYTE, ChBslash, 1'b0);
		push_req(REQ_BYTE, ChLowB, 1'b0);
		push_esc(ChLowN);
		push_esc(ChLowT);
		push_esc(ChBslash);
		push_esc(ChZero);
		repeat (3) push_byte(ChSeven);
		push_esc(ChZero);
		push_byte(ChZero + 8'd5);
		push_byte(ChBslash);
		push_byte("q");
		push_byte(ChBslash);
		push_req(REQ_END, 8'h00, 1'b0);
		push_esc(ChZero);
		push_byte(ChZero + 8'd3);
		push_req(REQ_END, 8'hFF, 1'b1);
		push_req(REQ_BYTE, 8'h00, 1'b1);
		push_byte(8'hFF);
		push_req(REQ_END, 8'h00, 1'b1);
		push_byte(ChBslash);
		drive_plan();
		wait_drain();

		// escape left pending across the switch to quote mode
		write_quote(1'b1);
		push_byte(ChLowN);
		push_byte(ChSpace);
		push_byte(ChBslash);
		push_byte("a");
		push_req(REQ_END, 8'h00, 1'b1);
		drive_plan();
		wait_drain();
		n_directed = n_items;

		foreach (q_plan[i]) begin
			if (i == 1)
				hold_armed = 1'b1;
			run_random(q_plan[i]);
		end

		// stop escape last: nothing may come out after it
		write_quote(1'b0);
		repeat (40) gen_arg();
		push_req(REQ_END, 8'h00, 1'b0);
		stop_allowed = 1'b1;
		push_esc(ChLowC);
		repeat (3) push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
		drive_plan();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.expected_q.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.expected_q.size());
		end
		$display("Covered %0d items (%0d directed), %0d results checked, quote off and on.",
			n_items, n_directed, sb.n_results);
		$display("Stop escape reported %0d time(s); one %0d-cycle output hold-off applied.",
			sb.n_stops, HoldCycles);
		if (sb.errors == 0 && reg_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/ecd_pkg.sv
rtl/ecd_front.sv
rtl/ecd_queue.sv
rtl/ecd_back.sv
rtl/echo_escape_decoder_unit.sv
tb/tb_echo_escape_decoder_unit.sv
